// ----- rtl/core/rrk_pkg.sv -----
package rrk_pkg;

  localparam int ROAD_CELLS = 128;
  localparam int CELL_W     = $clog2(ROAD_CELLS);
  localparam int LEN_W      = 8;
  localparam int RATE_W     = 7;
  localparam int FRAC_W     = 32;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 64;
  localparam int TGT_W      = FRAC_W + RATE_W;

  localparam logic [CFG_ADDR_W-1:0] REG_ROAD_LENGTH = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LOW   = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_HIGH  = 8'd2;

  localparam logic [LEN_W-1:0]      LEN_MIN         = 8'd2;
  localparam logic [LEN_W-1:0]      LEN_MAX         = 8'd128;
  localparam logic [LEN_W-1:0]      RST_ROAD_LENGTH = 8'd100;
  localparam logic [CFG_DATA_W-1:0] RST_START_LOW   = 64'h5555_5555_5555_5555;
  localparam logic [CFG_DATA_W-1:0] RST_START_HIGH  = 64'h0000_0005_5555_5555;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] from_cell;
    logic [CELL_W-1:0] to_cell;
  } road_move_t;

endpackage

// ----- rtl/core/rrk_if.sv -----
interface rrk_step_if;
  logic                         valid;
  logic                         ready;
  logic [rrk_pkg::FRAC_W-1:0]   random_fraction;
  logic                         restart;
  modport source(output valid, random_fraction, restart, input ready);
  modport sink(input valid, random_fraction, restart, output ready);
endinterface

interface rrk_result_if;
  logic                         valid;
  logic                         ready;
  logic                         moved;
  logic [rrk_pkg::CELL_W-1:0]   from_cell;
  logic [rrk_pkg::CELL_W-1:0]   to_cell;
  logic [rrk_pkg::RATE_W-1:0]   total_rate;
  modport source(output valid, moved, from_cell, to_cell, total_rate, input ready);
  modport sink(input valid, moved, from_cell, to_cell, total_rate, output ready);
endinterface

interface rrk_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrk_pkg::CFG_ADDR_W-1:0] addr;
  logic [rrk_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// ----- rtl/core/rrk_road.sv -----
module rrk_road (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [rrk_pkg::ROAD_CELLS-1:0]     load_bits,
  input  rrk_pkg::road_move_t                move,
  input  logic [rrk_pkg::CELL_W-1:0]         rd_idx,
  output logic                               rd_bit
);

  logic [rrk_pkg::ROAD_CELLS-1:0] road;
  logic [rrk_pkg::ROAD_CELLS-1:0] road_next;

  always_comb begin
    road_next = road;
    if (move.en) begin
      road_next[move.from_cell] = 1'b0;
      road_next[move.to_cell]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      road <= rrk_pkg::ROAD_CELLS'({rrk_pkg::RST_START_HIGH, rrk_pkg::RST_START_LOW});
    end else if (load) begin
      road <= load_bits;
    end else begin
      road <= road_next;
    end
  end

  assign rd_bit = road[rd_idx];

endmodule

// ----- rtl/core/ring_road_kmc_step.sv -----
// Ring road step engine.
// cfg: register writes (addr 0 road_length, 1 start_road_low, 2 start_road_high);
//   always ready, write only while the block is idle. Start bits take effect at
//   the next restart; a road_length write forces a recount on the next step.
// step: one word per step, random_fraction and restart. Ready only while idle.
// result: one word per step: moved, from_cell, to_cell, total_rate.
// A restart word reloads the road and answers with a result word, moved low.
// A move step walks the ring one cell per cycle through a single running
// counter and compare: a multiply state forms the product u*RN, the scan
// state steps the cells (it stops at the chosen car, and is skipped when the
// total rate is zero), and the done state posts the result.
// The first move step after reset, a restart or a road_length write first
// counts the empty cells in a count state before the multiply.
// One step at a time: step is ready again in the cycle its result turns valid.
// Reset loads the road from the reset start bits and clears the result
// valid flag. When result stalls, the finished word holds in the result register;
// a following step finishes, then waits with step ready low until it frees.
module ring_road_kmc_step (
  input  logic               clk,
  input  logic               rst,
  rrk_cfg_if.sink            cfg,
  rrk_step_if.sink           step,
  rrk_result_if.source       result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COUNT = 5'b00010,
    S_MUL   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [rrk_pkg::LEN_W-1:0]      road_length;
  logic [rrk_pkg::CFG_DATA_W-1:0] start_low;
  logic [rrk_pkg::CFG_DATA_W-1:0] start_high;

  logic [rrk_pkg::LEN_W-1:0]  n_use;
  logic [rrk_pkg::LEN_W-1:0]  last_idx;
  logic [rrk_pkg::RATE_W-1:0] total_c;

  logic [rrk_pkg::CELL_W-1:0] idx;
  logic [rrk_pkg::LEN_W-1:0]  emp_total;
  logic                       count_ok;
  logic [rrk_pkg::FRAC_W-1:0] frac;
  logic [rrk_pkg::TGT_W-1:0]  target;
  logic [rrk_pkg::RATE_W-1:0] total;
  logic [rrk_pkg::LEN_W-1:0]  emp;
  logic [rrk_pkg::RATE_W-1:0] lead;
  logic                       seen;
  logic [rrk_pkg::CELL_W-1:0] prev;

  logic                       res_moved;
  logic [rrk_pkg::CELL_W-1:0] res_from;
  logic [rrk_pkg::CELL_W-1:0] res_to;
  logic [rrk_pkg::RATE_W-1:0] res_total;

  logic                       out_valid;
  logic                       out_moved;
  logic [rrk_pkg::CELL_W-1:0] out_from;
  logic [rrk_pkg::CELL_W-1:0] out_to;
  logic [rrk_pkg::RATE_W-1:0] out_total;

  logic                       cur_bit;
  logic                       at_last;
  logic                       step_acc;
  logic                       out_space;
  logic [rrk_pkg::LEN_W-1:0]  c_prev;
  logic                       hit;
  logic [rrk_pkg::CELL_W-1:0] pick;
  logic                       pick_now;
  rrk_pkg::road_move_t        move;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      road_length <= rrk_pkg::RST_ROAD_LENGTH;
      start_low   <= rrk_pkg::RST_START_LOW;
      start_high  <= rrk_pkg::RST_START_HIGH;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        rrk_pkg::REG_ROAD_LENGTH: road_length <= cfg.data[rrk_pkg::LEN_W-1:0];
        rrk_pkg::REG_START_LOW:   start_low   <= cfg.data;
        rrk_pkg::REG_START_HIGH:  start_high  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_use = road_length;
    if (n_use < rrk_pkg::LEN_MIN) n_use = rrk_pkg::LEN_MIN;
    if (n_use > rrk_pkg::LEN_MAX) n_use = rrk_pkg::LEN_MAX;
  end

  assign last_idx = n_use - 8'd1;
  assign at_last  = ({1'b0, idx} == last_idx);
  assign total_c  = (emp_total != '0 && emp_total != n_use) ?
                    emp_total[rrk_pkg::RATE_W-1:0] : '0;

  assign step.ready = (state == S_IDLE);
  assign step_acc   = step.valid && step.ready;
  assign out_space  = !out_valid || result.ready;

  assign c_prev = emp - {1'b0, lead};
  assign hit    = (c_prev != '0) &&
                  ({c_prev[rrk_pkg::RATE_W-1:0], {rrk_pkg::FRAC_W{1'b0}}} >= target);

  // first car whose running sum reaches the target, else the last car seen
  always_comb begin
    pick_now = 1'b0;
    pick     = prev;
    if (cur_bit && seen && hit) begin
      pick_now = 1'b1;
    end else if (at_last) begin
      pick_now = 1'b1;
      if (cur_bit) pick = idx;
    end
  end

  always_comb begin
    move.en        = (state == S_DONE) && out_space && res_moved;
    move.from_cell = res_from;
    move.to_cell   = res_to;
  end

  rrk_road u_road (
    .clk       (clk),
    .rst       (rst),
    .load      (step_acc && step.restart),
    .load_bits (rrk_pkg::ROAD_CELLS'({start_high, start_low})),
    .move      (move),
    .rd_idx    (idx),
    .rd_bit    (cur_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_ok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((cfg.valid && cfg.addr == rrk_pkg::REG_ROAD_LENGTH) ||
          (step_acc && step.restart)) begin
        count_ok <= 1'b0;
      end else if (state == S_COUNT && at_last) begin
        count_ok <= 1'b1;
      end
      if (state == S_DONE && out_space) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (step_acc) begin
            frac <= step.random_fraction;
            idx  <= '0;
            if (step.restart) begin
              res_moved <= 1'b0;
              res_from  <= '0;
              res_to    <= '0;
              res_total <= '0;
              state     <= S_DONE;
            end else if (count_ok) begin
              state <= S_MUL;
            end else begin
              emp_total <= '0;
              state     <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          emp_total <= emp_total + {7'd0, !cur_bit};
          if (at_last) begin
            state <= S_MUL;
          end else begin
            idx <= idx + 7'd1;
          end
        end
        S_MUL: begin
          target <= rrk_pkg::TGT_W'(frac) * rrk_pkg::TGT_W'(total_c);
          total  <= total_c;
          idx    <= '0;
          emp    <= '0;
          lead   <= '0;
          seen   <= 1'b0;
          prev   <= '0;
          if (total_c == '0) begin
            res_moved <= 1'b0;
            res_from  <= '0;
            res_to    <= '0;
            res_total <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!cur_bit) begin
            emp <= emp + 8'd1;
          end else begin
            prev <= idx;
            if (!seen) begin
              seen <= 1'b1;
              lead <= emp[rrk_pkg::RATE_W-1:0];
            end
          end
          if (pick_now) begin
            res_moved <= 1'b1;
            res_from  <= pick;
            res_to    <= ({1'b0, pick} == last_idx) ? '0 : pick + 7'd1;
            res_total <= total;
            state     <= S_DONE;
          end else begin
            idx <= idx + 7'd1;
          end
        end
        S_DONE: begin
          if (out_space) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_space) begin
      out_moved <= res_moved;
      out_from  <= res_from;
      out_to    <= res_to;
      out_total <= res_total;
    end
  end

  assign result.valid      = out_valid;
  assign result.moved      = out_moved;
  assign result.from_cell  = out_from;
  assign result.to_cell    = out_to;
  assign result.total_rate = out_total;

endmodule
